>>> rtl/backlight_inactivity_dimmer_core_macros.svh
// Assertion macros for the backlight dimmer checker.
`ifndef BACKLIGHT_INACTIVITY_DIMMER_CORE_MACROS_SVH
`define BACKLIGHT_INACTIVITY_DIMMER_CORE_MACROS_SVH

`define BID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`define BID_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> rtl/bid_pkg.sv
package bid_pkg;

  localparam int MIN_TIMEOUT_S_DEF = 15;
  localparam int MAX_TIMEOUT_S_DEF = 300;

  localparam int LEVEL_W   = 8;
  localparam int TIMEOUT_W = 12;
  localparam int NOW_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  localparam int MS_PER_S  = 1000;
  localparam int FADE_STEP = 8;
  localparam int FADE_SH   = 3;

  localparam logic [LEVEL_W-1:0]   BRIGHTNESS_RST = 8'd255;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 12'd15;
  localparam logic                 DISABLED_RST   = 1'b0;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISABLED   = 2'd2;

  localparam logic [2:0] OP_LOOP     = 3'd0;
  localparam logic [2:0] OP_ACTIVITY = 3'd1;
  localparam logic [2:0] OP_STANDBY  = 3'd2;
  localparam logic [2:0] OP_WAKEUP   = 3'd3;
  localparam logic [2:0] OP_SILENT   = 3'd4;

  typedef enum logic [1:0] {
    MODE_AWAKE   = 2'd0,
    MODE_SILENT  = 2'd1,
    MODE_STANDBY = 2'd2
  } bid_mode_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [NOW_W-1:0] now_ms;
  } bid_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] backlight_level;
    logic [LEVEL_W-1:0] target_level;
    logic [1:0]         power_mode;
  } bid_out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] brightness;
    logic               disabled;
  } bid_cfg_t;

endpackage

>>> rtl/backlight_inactivity_dimmer_core.sv
// Backlight inactivity dimmer. Each item (an event code and a millisecond
// timestamp) updates the backlight level, its target and the power mode, and
// yields one result item with the state after the event. The block takes one
// item every cycle while its result items are taken. An accepted item is
// loaded into the input register; the state update then loads the result
// register, which offers the result item until it is taken. While a result
// item waits, one more item can be held in the input register before the
// input stops being ready. Configuration writes are registered and apply to
// the items processed after them, including the derived timeout and
// fade-start times that are worked out when a register is written.
module backlight_inactivity_dimmer_core import bid_pkg::*; #(
  parameter int MIN_TIMEOUT_S = MIN_TIMEOUT_S_DEF,
  parameter int MAX_TIMEOUT_S = MAX_TIMEOUT_S_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bid_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bid_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int TOP_S  = (MIN_TIMEOUT_S > MAX_TIMEOUT_S) ? MIN_TIMEOUT_S : MAX_TIMEOUT_S;
  localparam int TMS_RAW = $clog2(TOP_S * MS_PER_S + 1);
  localparam int TMS_W  = (TMS_RAW > FADE_SH + LEVEL_W) ? TMS_RAW : (FADE_SH + LEVEL_W);

  logic     s1_valid_r, s1_valid_nxt;
  bid_in_t  s1_item_r;
  logic     out_valid_r, out_valid_nxt;
  bid_out_t out_item_r;
  logic     fire;
  logic     take;

  bid_cfg_t         cfg;
  logic [TMS_W-1:0] t_ms;
  logic [TMS_W-1:0] fade_start;
  bid_out_t         result;

  bid_cfg #(
    .MIN_TIMEOUT_S(MIN_TIMEOUT_S),
    .MAX_TIMEOUT_S(MAX_TIMEOUT_S),
    .TMS_W        (TMS_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .t_ms      (t_ms),
    .fade_start(fade_start)
  );

  bid_engine #(
    .TMS_W(TMS_W)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .cfg       (cfg),
    .t_ms      (t_ms),
    .fade_start(fade_start),
    .result    (result)
  );

  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> rtl/bid_cfg.sv
module bid_cfg import bid_pkg::*; #(
  parameter int MIN_TIMEOUT_S = MIN_TIMEOUT_S_DEF,
  parameter int MAX_TIMEOUT_S = MAX_TIMEOUT_S_DEF,
  parameter int TMS_W         = 22
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output bid_cfg_t             cfg,
  output logic [TMS_W-1:0]     t_ms,
  output logic [TMS_W-1:0]     fade_start
);

  localparam int RST_TO_S = (int'(TIMEOUT_RST) < MIN_TIMEOUT_S) ? MIN_TIMEOUT_S :
                            ((int'(TIMEOUT_RST) > MAX_TIMEOUT_S) ? MAX_TIMEOUT_S :
                             int'(TIMEOUT_RST));
  localparam int RST_TMS  = RST_TO_S * MS_PER_S;
  localparam int RST_WIN  = int'(BRIGHTNESS_RST) * FADE_STEP;
  localparam int RST_ST   = (RST_TMS > RST_WIN) ? (RST_TMS - RST_WIN) : 0;

  logic [LEVEL_W-1:0] brightness_r, brightness_nxt;
  logic               disabled_r, disabled_nxt;
  logic [TMS_W-1:0]   t_ms_r, t_ms_nxt;
  logic [TMS_W-1:0]   start_r, start_nxt;
  logic [TIMEOUT_W-1:0] clamped;

  function automatic logic [TMS_W-1:0] start_of(input logic [TMS_W-1:0] tms,
                                                input logic [LEVEL_W-1:0] bri);
    logic [TMS_W-1:0] win;
    win = TMS_W'({bri, FADE_SH'(0)});
    return (tms > win) ? (tms - win) : '0;
  endfunction

  always_comb begin
    if (cfg_wdata[TIMEOUT_W-1:0] < TIMEOUT_W'(MIN_TIMEOUT_S)) begin
      clamped = TIMEOUT_W'(MIN_TIMEOUT_S);
    end else if (cfg_wdata[TIMEOUT_W-1:0] > TIMEOUT_W'(MAX_TIMEOUT_S)) begin
      clamped = TIMEOUT_W'(MAX_TIMEOUT_S);
    end else begin
      clamped = cfg_wdata[TIMEOUT_W-1:0];
    end
  end

  always_comb begin
    brightness_nxt = brightness_r;
    disabled_nxt   = disabled_r;
    t_ms_nxt       = t_ms_r;
    start_nxt      = start_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS: begin
          brightness_nxt = cfg_wdata[LEVEL_W-1:0];
          start_nxt      = start_of(t_ms_r, cfg_wdata[LEVEL_W-1:0]);
        end
        CFG_TIMEOUT: begin
          t_ms_nxt  = TMS_W'(clamped) * TMS_W'(MS_PER_S);
          start_nxt = start_of(TMS_W'(clamped) * TMS_W'(MS_PER_S), brightness_r);
        end
        CFG_DISABLED: begin
          disabled_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHTNESS_RST;
      disabled_r   <= DISABLED_RST;
      t_ms_r       <= TMS_W'(RST_TMS);
      start_r      <= TMS_W'(RST_ST);
    end else begin
      brightness_r <= brightness_nxt;
      disabled_r   <= disabled_nxt;
      t_ms_r       <= t_ms_nxt;
      start_r      <= start_nxt;
    end
  end

  assign cfg.brightness = brightness_r;
  assign cfg.disabled   = disabled_r;
  assign t_ms           = t_ms_r;
  assign fade_start     = start_r;

endmodule

>>> rtl/bid_engine.sv
module bid_engine import bid_pkg::*; #(
  parameter int TMS_W = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bid_in_t          item,
  input  bid_cfg_t         cfg,
  input  logic [TMS_W-1:0] t_ms,
  input  logic [TMS_W-1:0] fade_start,
  output bid_out_t         result
);

  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [LEVEL_W-1:0] goal_r, goal_nxt;
  logic [NOW_W-1:0]   last_r, last_nxt;
  bid_mode_t          mode_r, mode_nxt;

  logic [NOW_W-1:0]   inactive;
  logic [TMS_W-1:0]   remain;
  logic [LEVEL_W-1:0] goal_calc;
  logic [LEVEL_W-1:0] level_ramp;

  assign inactive = item.now_ms - last_r;
  assign remain   = t_ms - inactive[TMS_W-1:0];

  always_comb begin
    if (cfg.disabled) begin
      goal_calc = cfg.brightness;
    end else if (inactive >= NOW_W'(t_ms)) begin
      goal_calc = '0;
    end else if (inactive > NOW_W'(fade_start)) begin
      goal_calc = remain[FADE_SH +: LEVEL_W];
    end else begin
      goal_calc = cfg.brightness;
    end
  end

  always_comb begin
    if (level_r < goal_r) begin
      level_ramp = level_r + LEVEL_W'(1);
    end else if (level_r > goal_r) begin
      level_ramp = level_r - LEVEL_W'(1);
    end else begin
      level_ramp = level_r;
    end
  end

  always_comb begin
    level_nxt = level_r;
    goal_nxt  = goal_r;
    last_nxt  = last_r;
    mode_nxt  = mode_r;
    unique case (item.op)
      OP_LOOP: begin
        if (mode_r == MODE_AWAKE) begin
          level_nxt = level_ramp;
          goal_nxt  = goal_calc;
        end
      end
      OP_ACTIVITY: begin
        last_nxt = item.now_ms;
      end
      OP_STANDBY: begin
        level_nxt = '0;
        goal_nxt  = '0;
        mode_nxt  = MODE_STANDBY;
      end
      OP_WAKEUP: begin
        last_nxt  = item.now_ms;
        level_nxt = '0;
        goal_nxt  = cfg.brightness;
        mode_nxt  = MODE_AWAKE;
      end
      OP_SILENT: begin
        last_nxt  = item.now_ms;
        level_nxt = '0;
        goal_nxt  = '0;
        mode_nxt  = MODE_SILENT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      goal_r  <= '0;
      last_r  <= '0;
      mode_r  <= MODE_AWAKE;
    end else if (fire) begin
      level_r <= level_nxt;
      goal_r  <= goal_nxt;
      last_r  <= last_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign result.backlight_level = level_nxt;
  assign result.target_level    = goal_nxt;
  assign result.power_mode      = mode_nxt;

endmodule

>>> rtl/bid_checker.sv
`include "backlight_inactivity_dimmer_core_macros.svh"

module bid_checker import bid_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input bid_out_t out_data
);

  `BID_ASSERT(a_reset_empty, !rst_n |=> !out_valid, "Result valid straight after reset.")
  `BID_ASSERT_RST(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "Stalled result item changed.")
  `BID_ASSERT_RST(a_dark_asleep, out_valid && out_data.power_mode != MODE_AWAKE |-> out_data.backlight_level == '0 && out_data.target_level == '0, "Backlight lit outside the awake mode.")
  `BID_ASSERT_RST(a_item_out, in_valid && in_ready |=> ##1 out_valid, "Accepted item produced no result.")

endmodule

bind backlight_inactivity_dimmer_core bid_checker u_bid_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> test/backlight_inactivity_dimmer_core_test.sv
`timescale 1ns / 1ps

module backlight_inactivity_dimmer_core_test;
  import bid_pkg::*;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;

  class dimmer_scoreboard;
    logic [LEVEL_W-1:0]   bright;
    logic [TIMEOUT_W-1:0] tmo_s;
    logic                 tmo_off;
    logic [LEVEL_W-1:0]   level;
    logic [LEVEL_W-1:0]   goal;
    logic [NOW_W-1:0]     last_act;
    bid_mode_t            mode;
    bid_out_t             pending_levels[$];
    int                   faults;
    int                   results_seen;
    int                   items_seen;

    function new();
      bright = BRIGHTNESS_RST;
      tmo_s = TIMEOUT_RST;
      tmo_off = DISABLED_RST;
      level = '0;
      goal = '0;
      last_act = '0;
      mode = MODE_AWAKE;
      faults = 0;
      results_seen = 0;
      items_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_BRIGHTNESS: bright = val[LEVEL_W-1:0];
        CFG_TIMEOUT:    tmo_s = val[TIMEOUT_W-1:0];
        CFG_DISABLED:   tmo_off = val[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] limit_ms();
      logic [31:0] secs;
      secs = {20'd0, tmo_s};
      if (secs < MIN_TIMEOUT_S_DEF) secs = MIN_TIMEOUT_S_DEF;
      else if (secs > MAX_TIMEOUT_S_DEF) secs = MAX_TIMEOUT_S_DEF;
      return secs * MS_PER_S;
    endfunction

    function logic [31:0] fade_start();
      logic [31:0] t;
      logic [31:0] w;
      t = limit_ms();
      w = {21'd0, bright, 3'd0};
      return (t > w) ? t - w : 32'd0;
    endfunction

    function logic [LEVEL_W-1:0] goal_for(logic [NOW_W-1:0] now);
      logic [31:0] t;
      logic [31:0] idle;
      logic [31:0] fade;
      if (tmo_off) return bright;
      t = limit_ms();
      idle = now - last_act;
      if (idle >= t) return '0;
      if (idle > fade_start()) begin
        fade = (t - idle) >> FADE_SH;
        return fade[LEVEL_W-1:0];
      end
      return bright;
    endfunction

    function void note_input(bid_in_t it);
      bid_out_t e;
      case (it.op)
        OP_LOOP: begin
          if (mode == MODE_AWAKE) begin
            if (level < goal) level = level + 1'b1;
            else if (level > goal) level = level - 1'b1;
            goal = goal_for(it.now_ms);
          end
        end
        OP_ACTIVITY: last_act = it.now_ms;
        OP_STANDBY: begin
          level = '0;
          goal = '0;
          mode = MODE_STANDBY;
        end
        OP_WAKEUP: begin
          last_act = it.now_ms;
          level = '0;
          goal = bright;
          mode = MODE_AWAKE;
        end
        OP_SILENT: begin
          last_act = it.now_ms;
          level = '0;
          goal = '0;
          mode = MODE_SILENT;
        end
        default: ;
      endcase
      e.backlight_level = level;
      e.target_level = goal;
      e.power_mode = mode;
      pending_levels.push_back(e);
      items_seen++;
    endfunction

    function void check_result(bid_out_t got);
      bid_out_t e;
      results_seen++;
      if (pending_levels.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("Unexpected result item: level %0d target %0d mode %0d",
                   got.backlight_level, got.target_level, got.power_mode);
        return;
      end
      e = pending_levels.pop_front();
      if (got.backlight_level !== e.backlight_level || got.target_level !== e.target_level ||
          got.power_mode !== e.power_mode) begin
        faults++;
        if (faults <= 10)
          $display("Result %0d differs: expected level %0d target %0d mode %0d, got %0d %0d %0d",
                   results_seen, e.backlight_level, e.target_level, e.power_mode,
                   got.backlight_level, got.target_level, got.power_mode);
      end
    endfunction

    function int pending();
      return pending_levels.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  bid_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  bid_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  dimmer_scoreboard sb = new();
  bit   no_idle = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   phases = 0;

  backlight_inactivity_dimmer_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out after %0d cycles without progress", IDLE_LIMIT);
        $display("[backlight_inactivity_dimmer_core] ERROR");
        $finish;
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge that follows
  // the acceptance of the item.
  task automatic send_item(input logic [2:0] op, input logic [NOW_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op: op, now_ms: now};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] bright, input logic [11:0] tmo,
                            input logic tmo_off);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BRIGHTNESS;
    cfg_wdata <= {4'd0, bright};
    sb.set_reg(CFG_BRIGHTNESS, {4'd0, bright});
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    sb.set_reg(CFG_TIMEOUT, tmo);
    @(negedge clk);
    cfg_index <= CFG_DISABLED;
    cfg_wdata <= {11'd0, tmo_off};
    sb.set_reg(CFG_DISABLED, {11'd0, tmo_off});
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    phases++;
  endtask

  // Offsets from the last activity, weighted towards the fade window and its edges.
  function automatic logic [31:0] pick_offset();
    logic [31:0] t;
    logic [31:0] s;
    int r;
    t = sb.limit_ms();
    s = sb.fade_start();
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom_range(0, s);
      1: return s - 1 + $urandom_range(0, 2);
      3: return t - 1 + $urandom_range(0, 2);
      4: return t + $urandom_range(0, 100000);
      5: return $urandom;
      default: return $urandom_range(s, t);
    endcase
  endfunction

  task automatic run_random(input int n);
    int sent;
    int steps;
    int r;
    logic [31:0] base;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        base = $urandom;
        r = $urandom_range(0, 99);
        if (r < 70) send_item(OP_WAKEUP, base);
        else if (r < 90) send_item(OP_ACTIVITY, base);
        else send_item(OP_SILENT, base);
        steps = $urandom_range(2, 14);
        sent += steps + 1;
        repeat (steps) begin
          if ($urandom_range(0, 15) == 0) send_item(OP_ACTIVITY, base + pick_offset());
          else send_item(OP_LOOP, base + pick_offset());
        end
      end else begin
        r = $urandom_range(0, 3);
        if (r == 0) send_item(3'($urandom_range(0, 7)), $urandom);
        else send_item(3'($urandom_range(0, 7)), sb.last_act + pick_offset());
        sent++;
      end
    end
  endtask

  initial begin
    int drain;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_LOOP, 32'd0);
    send_item(OP_LOOP, 32'd1);
    send_item(OP_WAKEUP, 32'd1000);
    send_item(OP_LOOP, 32'd13960);
    send_item(OP_LOOP, 32'd13961);
    send_item(OP_LOOP, 32'd15999);
    send_item(OP_LOOP, 32'd16000);
    send_item(OP_LOOP, 32'hFFFF_FFFF);
    send_item(OP_ACTIVITY, 32'hFFFF_FFF0);
    send_item(OP_LOOP, 32'h0000_0010);
    send_item(OP_LOOP, 32'h0000_36A0);
    send_item(OP_STANDBY, 32'h5555_5555);
    send_item(OP_LOOP, 32'hAAAA_AAAA);
    send_item(OP_ACTIVITY, 32'h1234_5678);
    send_item(OP_LOOP, 32'h1234_5679);
    send_item(OP_SILENT, 32'd123);
    send_item(OP_LOOP, 32'd200);
    send_item(OP_RSVD5, 32'hFFFF_FFFF);
    send_item(OP_RSVD6, 32'd0);
    send_item(OP_RSVD7, $urandom);
    send_item(OP_WAKEUP, 32'd0);
    send_item(OP_LOOP, 32'd0);
    send_item(OP_LOOP, 32'd14000);
    run_random(120);

    set_config(8'd0, 12'd0, 1'b0);
    run_random(80);
    set_config(8'd255, 12'd4095, 1'b0);
    run_random(80);
    set_config(8'd1, 12'd14, 1'b0);
    run_random(60);
    set_config(8'd200, 12'd16, 1'b1);
    run_random(60);
    no_idle = 1'b1;
    set_config(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)), 1'b0);
    run_random(80);
    no_idle = 1'b0;
    set_config(8'd128, 12'd300, 1'b0);
    run_random(80);
    set_config(BRIGHTNESS_RST, TIMEOUT_RST, DISABLED_RST);
    run_random(60);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    drain = DRAIN_CYCLES;
    repeat (drain) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.faults++;
      $display("%0d expected result items never arrived", sb.pending());
    end

    $display("Sent %0d items and checked %0d results over %0d register settings.",
             sb.items_seen, sb.results_seen, phases + 1);
    $display("Ramp, fade window edges, timeout clamping, wrap and idle modes were exercised.");
    if (sb.faults == 0) begin
      $display("[backlight_inactivity_dimmer_core] OK");
    end else begin
      $display("%0d failures in total", sb.faults);
      $display("[backlight_inactivity_dimmer_core] ERROR");
    end
    $finish;
  end

endmodule
